// ----- rtl/assert_macros.svh -----
// Assertion macros used by the heap sort engine RTL.
// Self-contained; the including module supplies clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that an expression holds at every clock edge outside reset.
`define HSE_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

// Checks that a property holds at every clock edge outside reset.
`define HSE_ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`else

`define HSE_ASSERT(lbl, expr)
`define HSE_ASSERT_PROP(lbl, prop)

`endif

`endif

// ----- rtl/hse_pkg.sv -----
// Package for the heap sort engine: sizes, transaction types and sequencer states.
// No dependencies.
`default_nettype none

package hse_pkg;

  // Heap capacity and element width.
  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;

  // Heap index width and element count width (holds CAPACITY itself).
  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = ADDR_W + 1;

  // One input transaction.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         carries_value;
    logic                         last;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         final_res;
    logic                         empty_res;
    logic                         overflow;
  } out_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_UP_FIN,
    S_POP_RD0,
    S_POP_TOP,
    S_POP_MOV,
    S_DN_CHK,
    S_DN_C0,
    S_DN_C1,
    S_DN_DEC,
    S_EMIT
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/hse_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module hse_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/hse_core.sv -----
// Heap sequencer: sift-up on insert, sift-down on pop, with one shared comparator.
// Depends on hse_pkg, hse_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hse_core import hse_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output out_t      res_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  dropped_q, dropped_d;
  logic                  last_q, last_d;
  logic                  empty_q, empty_d;
  logic [ADDR_W-1:0]     pos_q, pos_d;
  logic [ADDR_W-1:0]     idx_q, idx_d;
  logic [DATA_WIDTH-1:0] v_q, v_d;
  logic [DATA_WIDTH-1:0] top_q, top_d;
  logic [DATA_WIDTH-1:0] moved_q, moved_d;
  logic [DATA_WIDTH-1:0] best_q, best_d;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [DATA_WIDTH-1:0] cmp_a, cmp_b;
  logic                  cmp_lt;
  logic [ADDR_W-1:0]     parent;
  logic [CNT_W-1:0]      child, sib, cnt_m1;
  logic                  child_lt_cnt, sib_lt_cnt, cnt_full, ins_ok;

  // Heap storage.
  hse_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(DATA_WIDTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Index arithmetic for the heap tree.
  assign parent       = (pos_q - ADDR_W'(1)) >> 1;
  assign child        = {pos_q, 1'b1};
  assign sib          = child + CNT_W'(1);
  assign cnt_m1       = cnt_q - CNT_W'(1);
  assign child_lt_cnt = child < cnt_q;
  assign sib_lt_cnt   = sib < cnt_q;
  assign cnt_full     = cnt_q == CNT_W'(CAPACITY);
  assign ins_ok       = in_data_i.carries_value && !cnt_full;

  // The one shared signed comparator; operands depend on the step.
  always_comb begin
    case (state_q)
      S_UP_CMP: begin
        cmp_a = v_q;
        cmp_b = ram_rdata;
      end
      S_DN_C1: begin
        cmp_a = ram_rdata;
        cmp_b = best_q;
      end
      default: begin
        cmp_a = best_q;
        cmp_b = moved_q;
      end
    endcase
  end
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (ins_ok) begin
            state_d = (cnt_q == '0) ? S_UP_FIN : S_UP_RD;
          end else if (in_data_i.last) begin
            state_d = (cnt_q == '0) ? S_EMIT : S_POP_RD0;
          end
        end
      end
      S_UP_RD:   state_d = S_UP_CMP;
      S_UP_CMP: begin
        if (cmp_lt) begin
          state_d = (parent == '0) ? S_UP_FIN : S_UP_RD;
        end else begin
          state_d = last_q ? S_POP_RD0 : S_IDLE;
        end
      end
      S_UP_FIN:  state_d = last_q ? S_POP_RD0 : S_IDLE;
      S_POP_RD0: state_d = S_POP_TOP;
      S_POP_TOP: state_d = (cnt_q == CNT_W'(1)) ? S_EMIT : S_POP_MOV;
      S_POP_MOV: state_d = S_DN_CHK;
      S_DN_CHK:  state_d = child_lt_cnt ? S_DN_C0 : S_EMIT;
      S_DN_C0:   state_d = sib_lt_cnt ? S_DN_C1 : S_DN_DEC;
      S_DN_C1:   state_d = S_DN_DEC;
      S_DN_DEC:  state_d = cmp_lt ? S_DN_CHK : S_EMIT;
      S_EMIT: begin
        if (res_ready_i) begin
          state_d = (cnt_q == '0) ? S_IDLE : S_POP_RD0;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath, memory port and handshake outputs.
  always_comb begin
    cnt_d     = cnt_q;
    dropped_d = dropped_q;
    last_d    = last_q;
    empty_d   = empty_q;
    pos_d     = pos_q;
    idx_d     = idx_q;
    v_d       = v_q;
    top_d     = top_q;
    moved_d   = moved_q;
    best_d    = best_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = v_q;
    ram_raddr = parent;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          last_d  = in_data_i.last;
          empty_d = in_data_i.last && !in_data_i.carries_value && (cnt_q == '0);
          if (in_data_i.carries_value && cnt_full) begin
            dropped_d = 1'b1;
          end
          if (ins_ok) begin
            v_d   = in_data_i.value;
            pos_d = cnt_q[ADDR_W-1:0];
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = ram_rdata;
          pos_d     = parent;
        end
      end
      S_UP_FIN: ram_we = 1'b1;
      S_POP_RD0: ram_raddr = '0;
      S_POP_TOP: begin
        top_d     = ram_rdata;
        cnt_d     = cnt_m1;
        ram_raddr = cnt_m1[ADDR_W-1:0];
      end
      S_POP_MOV: begin
        moved_d = ram_rdata;
        pos_d   = '0;
      end
      S_DN_CHK: begin
        ram_raddr = child[ADDR_W-1:0];
        if (!child_lt_cnt) begin
          ram_we    = 1'b1;
          ram_wdata = moved_q;
        end
      end
      S_DN_C0: begin
        best_d    = ram_rdata;
        idx_d     = child[ADDR_W-1:0];
        ram_raddr = sib[ADDR_W-1:0];
      end
      S_DN_C1: begin
        if (cmp_lt) begin
          best_d = ram_rdata;
          idx_d  = sib[ADDR_W-1:0];
        end
      end
      S_DN_DEC: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = best_q;
          pos_d     = idx_q;
        end else begin
          ram_wdata = moved_q;
        end
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i && (cnt_q == '0)) begin
          dropped_d = 1'b0;
          empty_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Result transaction built from the popped value and the run flags.
  assign res_o.sorted_value = empty_q ? '0 : top_q;
  assign res_o.final_res    = cnt_q == '0;
  assign res_o.empty_res    = empty_q;
  assign res_o.overflow     = dropped_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      dropped_q <= 1'b0;
      last_q    <= 1'b0;
      empty_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      dropped_q <= dropped_d;
      last_q    <= last_d;
      empty_q   <= empty_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    idx_q   <= idx_d;
    v_q     <= v_d;
    top_q   <= top_d;
    moved_q <= moved_d;
    best_q  <= best_d;
  end

  // The element count never passes the heap capacity.
  `HSE_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY))
  // An empty result is only given when nothing is stored.
  `HSE_ASSERT_PROP(a_empty_cnt, (res_valid_o && empty_q) |-> (cnt_q == '0))
  // The sift-down position always lies inside the live heap.
  `HSE_ASSERT_PROP(a_dn_pos, (state_q == S_DN_CHK) |-> ({1'b0, pos_q} < cnt_q))
  // Delivering the final result ends the run with the drop flag cleared.
  `HSE_ASSERT_PROP(a_run_end,
      (res_valid_o && res_ready_i && res_o.final_res) |=> (state_q == S_IDLE && !dropped_q))

endmodule

`default_nettype wire

// ----- rtl/heap_sort_engine.sv -----
// Top level of the heap sort engine: heap sequencer plus the result output register.
// Depends on hse_pkg and hse_core.
//
// Usage: values arrive on the input channel (in_valid_i, in_stall_o, in_data_i),
// one per transaction, with carries_value set when the value field holds an
// element. A transaction with last set closes the data set; the engine then
// sends every stored value in ascending order on the output channel
// (out_valid_o, out_stall_i, out_data_o), with final_res set on the last one.
// A data set with no values gives one result with empty_res set. Values that
// arrive once 64 are stored are dropped, and every result of that run shows
// overflow. An insert compares the new value with each parent in turn, moving
// each larger parent down a level, and writes the value where it settles. Each
// pop reads the root and the last element, then sifts that element down past
// each smaller child. All of this runs on one comparator and a single-read-port
// heap RAM with registered read data. Each result passes through the output
// register. The input is stalled while an insert or the drain is in progress.
// When the receiver stalls, the result waits in the output register and the
// drain pauses until that register frees up. Reset empties the heap and
// clears the drop flag; the RAM contents need no clearing.
`default_nettype none

module heap_sort_engine import hse_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic out_valid_q, out_valid_d;
  out_t out_data_q;
  logic res_valid, res_ready;
  out_t res;

  // Heap sequencer.
  hse_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // The output register takes a new result when empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
